// ===== rtl/socm_pkg.sv =====
// Shared types and constants for the shard offset chunk mapper.
`timescale 1ns / 1ps

package socm_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SHARD_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_CAP = 8'd1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NOSHARD = 2'd2;
	localparam logic [1:0] ST_BADCAP = 2'd3;

	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = 6;

	typedef struct packed {
		logic        kind;
		logic [12:0] entry_index;
		logic [63:0] entry_offset;
		logic [63:0] position;
		logic [63:0] request_length;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] shard_index;
		logic [63:0] local_offset;
		logic [63:0] block_index;
		logic [31:0] offset_in_block;
		logic [31:0] chunk_length;
	} result_t;

endpackage

// ===== rtl/socm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module socm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4097,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/socm_div.sv =====
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module socm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [31:0] remainder
);

	logic                              run_q;
	logic                              done_q;
	logic [socm_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [63:0]                       quo_q;
	logic [31:0]                       rem_q;
	logic [32:0]                       shifted;
	logic [32:0]                       diff;
	logic                              ge;

	assign shifted = {rem_q, quo_q[63]};
	assign diff = shifted - {1'b0, divisor};
	assign ge = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == socm_pkg::DIV_CNT_W'(socm_pkg::DIV_STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[62:0], ge};
			// The partial remainder stays below the divisor, so 32 bits hold it.
			rem_q <= ge ? diff[31:0] : shifted[31:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/shard_offset_chunk_mapper.sv =====
// Top level of the shard offset chunk mapper: table load, binary search and chunk sizing.
//
// Channel   Direction  Handshake                    Payload
// request   in         start && !busy               request (socm_pkg::request_t)
// result    out        result_valid, one cycle      result (socm_pkg::result_t)
// config    in         cfg_valid && cfg_ready       cfg_index, cfg_data
//
// A load item is written as it is taken. A lookup rejected on capacity or zero length
// answers the cycle after it is taken. Otherwise it reads the table total, makes up to
// clog2(MAX_SHARDS + 1) search probes and divides: each probe needs two reads of the
// single table read port, and the divider retires one quotient bit per cycle.
// Reset clears the sequencer, the result strobe and the configuration registers; the table needs no clearing pass.
// The receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps

module shard_offset_chunk_mapper #(
	parameter int MAX_SHARDS = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  socm_pkg::request_t                    request,
	output logic                                  result_valid,
	output socm_pkg::result_t                     result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [socm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [socm_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int DEPTH = MAX_SHARDS + 1;
	localparam int AW = $clog2(DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TOTAL = 3'd1;
	localparam logic [2:0] S_PROBE_A = 3'd2;
	localparam logic [2:0] S_PROBE_B = 3'd3;
	localparam logic [2:0] S_PROBE_C = 3'd4;
	localparam logic [2:0] S_DIV_GO = 3'd5;
	localparam logic [2:0] S_DIV_WAIT = 3'd6;
	localparam logic [2:0] S_FIN = 3'd7;

	logic [2:0]          state_q;
	logic [AW-1:0]       count_q;
	logic [31:0]         cap_q;
	logic [63:0]         pos_q;
	logic [63:0]         len_q;
	logic [63:0]         total_q;
	logic [63:0]         start_q;
	logic [63:0]         local_q;
	logic [63:0]         left_q;
	logic [63:0]         want_q;
	logic [63:0]         rest_q;
	logic [AW-1:0]       lo_q;
	logic [AW-1:0]       hi_q;
	logic [AW-1:0]       mid_q;
	logic                ge_start_q;
	logic                res_valid_q;
	socm_pkg::result_t   res_q;

	logic                accept;
	logic [31:0]         cfg_cnt_w;
	logic [31:0]         cnt_sat_w;
	logic [31:0]         load_addr_w;
	logic                ram_we;
	logic [AW-1:0]       ram_raddr;
	logic [63:0]         ram_rdata;
	logic [AW-1:0]       mid_w;
	logic [AW-1:0]       mid_inc_w;
	logic [AW-1:0]       lo_n;
	logic [AW-1:0]       hi_n;
	logic [31:0]         sel_w;
	logic [63:0]         tail_w;
	logic [63:0]         room_w;
	logic [63:0]         chunk_w;
	logic                div_start;
	logic                div_done;
	logic [63:0]         div_quo;
	logic [31:0]         div_rem;

	assign accept = start && !busy;
	assign busy = state_q != S_IDLE;
	assign cfg_ready = 1'b1;

	// Shard count saturates at MAX_SHARDS.
	assign cfg_cnt_w = {19'b0, cfg_data[12:0]};
	assign cnt_sat_w = (cfg_cnt_w > 32'(MAX_SHARDS)) ? 32'(MAX_SHARDS) : cfg_cnt_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				socm_pkg::REG_SHARD_COUNT: begin
					count_q <= cnt_sat_w[AW-1:0];
				end
				socm_pkg::REG_PAYLOAD_CAP: begin
					cap_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Table writes beyond the sentinel slot are dropped.
	assign load_addr_w = {19'b0, request.entry_index};
	assign ram_we = accept && (request.kind == socm_pkg::KIND_LOAD)
		&& (load_addr_w <= 32'(MAX_SHARDS));

	assign mid_w = lo_q + ((hi_q - lo_q) >> 1);
	assign mid_inc_w = mid_q + 1'b1;

	always_comb begin
		case (state_q)
			S_IDLE: begin
				ram_raddr = count_q;
			end
			S_PROBE_A: begin
				ram_raddr = mid_w;
			end
			default: begin
				ram_raddr = mid_inc_w;
			end
		endcase
	end

	socm_ram #(
		.WIDTH(64),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(load_addr_w[AW-1:0]),
		.wdata(request.entry_offset),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign div_start = state_q == S_DIV_GO;

	socm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (local_q),
		.divisor  (cap_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Next search bounds when the probed shard misses.
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (!ge_start_q) begin
			hi_n = mid_q;
		end else begin
			lo_n = mid_inc_w;
		end
	end

	assign sel_w = 32'(mid_q);
	assign tail_w = total_q - pos_q;
	assign room_w = {32'b0, cap_q - div_rem};
	assign chunk_w = (room_w < rest_q) ? room_w : rest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && request.kind == socm_pkg::KIND_LOOKUP) begin
						if (cap_q == '0 || request.request_length == '0) begin
							res_valid_q <= 1'b1;
						end else begin
							state_q <= S_TOTAL;
						end
					end
				end
				S_TOTAL: begin
					if (count_q == '0 || pos_q >= ram_rdata) begin
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PROBE_A;
					end
				end
				S_PROBE_A: begin
					state_q <= S_PROBE_B;
				end
				S_PROBE_B: begin
					state_q <= S_PROBE_C;
				end
				S_PROBE_C: begin
					if (ge_start_q && pos_q < ram_rdata) begin
						state_q <= S_DIV_GO;
					end else if (lo_n < hi_n) begin
						state_q <= S_PROBE_A;
					end else begin
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pos_q <= request.position;
				len_q <= request.request_length;
				res_q <= '0;
				if (cap_q == '0) begin
					res_q.status <= socm_pkg::ST_BADCAP;
				end
			end
			S_TOTAL: begin
				total_q <= ram_rdata;
				lo_q <= '0;
				hi_q <= count_q;
				res_q <= '0;
				res_q.status <= socm_pkg::ST_RANGE;
			end
			S_PROBE_A: begin
				mid_q <= mid_w;
			end
			S_PROBE_B: begin
				start_q <= ram_rdata;
				ge_start_q <= pos_q >= ram_rdata;
			end
			S_PROBE_C: begin
				local_q <= pos_q - start_q;
				// Bytes left in the shard: its end minus the position.
				left_q <= ram_rdata - pos_q;
				lo_q <= lo_n;
				hi_q <= hi_n;
				res_q <= '0;
				res_q.status <= socm_pkg::ST_NOSHARD;
			end
			S_DIV_GO: begin
				want_q <= (len_q < tail_w) ? len_q : tail_w;
			end
			S_DIV_WAIT: begin
				rest_q <= (left_q < want_q) ? left_q : want_q;
			end
			S_FIN: begin
				res_q.status <= socm_pkg::ST_OK;
				res_q.shard_index <= sel_w[11:0];
				res_q.local_offset <= local_q;
				res_q.block_index <= div_quo;
				res_q.offset_in_block <= div_rem;
				res_q.chunk_length <= chunk_w[31:0];
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule

// ===== rtl/socm_checker.sv =====
// Port-level checks for the shard offset chunk mapper, bound to its top level.
`timescale 1ns / 1ps

module socm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input socm_pkg::request_t request,
	input logic               result_valid,
	input socm_pkg::result_t  result
);

	// A load item never produces a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.kind == socm_pkg::KIND_LOAD |=> !result_valid)
		else $error("result after a load item");

	// Results only show once the sequencer has returned to idle.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

	// Every failing status carries all-zero fields.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != socm_pkg::ST_OK |->
		result.shard_index == '0 && result.local_offset == '0
		&& result.block_index == '0 && result.offset_in_block == '0
		&& result.chunk_length == '0)
		else $error("nonzero fields with a failing status");

	// The block only goes busy after taking a lookup item.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && request.kind == socm_pkg::KIND_LOOKUP))
		else $error("busy without a lookup item");

endmodule

bind shard_offset_chunk_mapper socm_checker u_socm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.request     (request),
	.result_valid(result_valid),
	.result      (result)
);

// ===== dv/tb.sv =====
// Testbench for the shard offset chunk mapper: directed table, random tables and lookups.
`timescale 1ns / 1ps

module tb;
	import socm_pkg::*;

	localparam int MAX_SHARDS = 4096;
	localparam int DRAIN_CYCLES = 128;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int EPISODES = 32;
	localparam int LOOKUPS_PER_TABLE = 20;
	localparam int WIDE_LOOKUPS = 40;
	localparam int MAX_REPORTS = 100;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;
	localparam logic [63:0] ALL_ONES = '1;

	typedef enum logic [1:0] {ROW_LOAD, ROW_LOOKUP, ROW_CFG} step_e;

	typedef struct {
		step_e       op;
		logic [12:0] slot;
		logic [63:0] value;
		logic [63:0] req_len;
		bit          pinned;
		logic [1:0]  status;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t request = '0;
	logic result_valid;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the block's table and registers.
	logic [63:0] mirror_start [0:MAX_SHARDS];
	int mirror_count = 0;
	logic [31:0] mirror_cap = '0;
	result_t chunk_pending [$];

	// Offsets the stimulus intends to hold in the table.
	logic [63:0] layout [0:MAX_SHARDS];

	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;

	// Pinned rows carry a result that is obvious from the rules; the rest use the predictor.
	plan_row_t directed [25] = '{
		'{ROW_LOAD,   13'd0,         64'd0,       64'd0,    1'b0, ST_OK},
		'{ROW_LOOKUP, 13'd0,         ALL_ONES,    ALL_ONES, 1'b1, ST_BADCAP},
		'{ROW_CFG,    REG_PAYLOAD_CAP, 64'd4096,  64'd0,    1'b0, ST_OK},
		'{ROW_LOOKUP, 13'd0,         ALL_ONES,    64'd0,    1'b1, ST_OK},
		'{ROW_LOOKUP, 13'd0,         64'd0,       64'd1,    1'b1, ST_RANGE},
		'{ROW_LOAD,   13'd1,         64'd4100,    64'd0,    1'b0, ST_OK},
		'{ROW_LOAD,   13'd2,         64'd1000000, 64'd0,    1'b0, ST_OK},
		'{ROW_LOAD,   13'd3,         ALL_ONES,    64'd0,    1'b0, ST_OK},
		'{ROW_CFG,    REG_SHARD_COUNT, 64'd3,     64'd0,    1'b0, ST_OK},
		'{ROW_LOOKUP, 13'd0,         64'd0,       ALL_ONES, 1'b0, ST_OK},
		'{ROW_LOOKUP, 13'd0,         64'd4099,    64'd10,   1'b0, ST_OK},
		'{ROW_LOOKUP, 13'd0,         64'd4100,    64'd1,    1'b0, ST_OK},
		'{ROW_LOOKUP, 13'd0,         ALL_ONES,    64'd1,    1'b1, ST_RANGE},
		'{ROW_LOOKUP, 13'd0,         ALL_ONES - 1, ALL_ONES, 1'b0, ST_OK},
		'{ROW_LOAD,   13'd8191,      ALL_ONES,    64'd0,    1'b0, ST_OK},
		'{ROW_LOAD,   13'd4096,      64'd0,       64'd0,    1'b0, ST_OK},
		'{ROW_CFG,    REG_PAYLOAD_CAP, 64'hFFFF_FFFF, 64'd0, 1'b0, ST_OK},
		'{ROW_LOOKUP, 13'd0,         64'd123456,  64'd5,    1'b0, ST_OK},
		'{ROW_CFG,    REG_PAYLOAD_CAP, 64'd1,     64'd0,    1'b0, ST_OK},
		'{ROW_LOOKUP, 13'd0,         64'd999999,  64'd7,    1'b0, ST_OK},
		'{ROW_LOAD,   13'd0,         64'd10,      64'd0,    1'b0, ST_OK},
		// The first shard now starts above the position, so the search runs out.
		'{ROW_LOOKUP, 13'd0,         64'd5,       64'd3,    1'b1, ST_NOSHARD},
		'{ROW_CFG,    REG_UNUSED_HI, 64'hFFFF_FFFF, 64'd0,  1'b0, ST_OK},
		'{ROW_CFG,    REG_UNUSED_LO, 64'd0,       64'd0,    1'b0, ST_OK},
		'{ROW_LOOKUP, 13'd0,         64'd20,      64'd3,    1'b0, ST_OK}
	};

	shard_offset_chunk_mapper #(.MAX_SHARDS(MAX_SHARDS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] min64(logic [63:0] a, logic [63:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic request_t rand_request();
		request_t r;
		r.kind = 1'($urandom);
		r.entry_index = 13'($urandom);
		r.entry_offset = rand64();
		r.position = rand64();
		r.request_length = rand64();
		return r;
	endfunction

	function automatic result_t map_position(request_t r);
		result_t o;
		logic [63:0] total, first, mass, local_off, cap64, off, want, chunk;
		int lo, hi, mid, sel;
		bit found;
		o = '0;
		cap64 = {32'b0, mirror_cap};
		found = 1'b0;
		sel = 0;
		lo = 0;
		hi = mirror_count;
		if (mirror_cap == 0) begin
			o.status = ST_BADCAP;
			return o;
		end
		if (r.request_length == 0) begin
			o.status = ST_OK;
			return o;
		end
		total = mirror_start[mirror_count];
		if (mirror_count == 0 || r.position >= total) begin
			o.status = ST_RANGE;
			return o;
		end
		while (lo < hi && !found) begin
			mid = lo + (hi - lo) / 2;
			if (r.position >= mirror_start[mid] && r.position < mirror_start[mid + 1]) begin
				found = 1'b1;
				sel = mid;
			end else if (r.position < mirror_start[mid]) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		if (!found) begin
			o.status = ST_NOSHARD;
			return o;
		end
		first = mirror_start[sel];
		mass = mirror_start[sel + 1] - first;
		local_off = r.position - first;
		off = local_off % cap64;
		want = min64(r.request_length, total - r.position);
		chunk = min64(min64(cap64 - off, mass - local_off), want);
		o.status = ST_OK;
		o.shard_index = sel[11:0];
		o.local_offset = local_off;
		o.block_index = local_off / cap64;
		o.offset_in_block = off[31:0];
		o.chunk_length = chunk[31:0];
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		if (errors < MAX_REPORTS)
			$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid) begin
			if (chunk_pending.size() == 0) begin
				report("result with no lookup pending", 64'(result.status), 64'd0);
			end else begin
				want = chunk_pending.pop_front();
				if (result.status !== want.status)
					report("status", 64'(result.status), 64'(want.status));
				if (result.shard_index !== want.shard_index)
					report("shard_index", 64'(result.shard_index), 64'(want.shard_index));
				if (result.local_offset !== want.local_offset)
					report("local_offset", result.local_offset, want.local_offset);
				if (result.block_index !== want.block_index)
					report("block_index", result.block_index, want.block_index);
				if (result.offset_in_block !== want.offset_in_block)
					report("offset_in_block", 64'(result.offset_in_block),
						64'(want.offset_in_block));
				if (result.chunk_length !== want.chunk_length)
					report("chunk_length", 64'(result.chunk_length), 64'(want.chunk_length));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// All tasks below are entered and left just after a falling edge.
	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic issue(request_t r, bit pinned, logic [1:0] st);
		result_t pinned_res;
		request = r;
		start = 1'b1;
		do begin
			@(posedge clk);
		end while (busy);
		if (r.kind == KIND_LOAD) begin
			if (r.entry_index <= MAX_SHARDS)
				mirror_start[r.entry_index] = r.entry_offset;
		end else if (pinned) begin
			pinned_res = '0;
			pinned_res.status = st;
			chunk_pending.push_back(pinned_res);
		end else begin
			chunk_pending.push_back(map_position(r));
		end
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		logic [12:0] cnt;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		if (idx == REG_SHARD_COUNT) begin
			cnt = val[12:0];
			mirror_count = (cnt > MAX_SHARDS) ? MAX_SHARDS : int'(cnt);
		end else if (idx == REG_PAYLOAD_CAP) begin
			mirror_cap = val;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (chunk_pending.size() != 0)
			@(negedge clk);
	endtask

	// A load leaves no result behind, so the block gets its full latency before a write.
	task automatic settle();
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_layout(int n);
		request_t r;
		bit down;
		int i;
		down = 1'($urandom);
		for (int k = 0; k <= n; k++) begin
			if ($urandom_range(9) == 0) begin
				r = rand_request();
				r.kind = KIND_LOAD;
				r.entry_index = 13'($urandom_range(MAX_SHARDS + 1, 8191));
				idle_gap();
				issue(r, 1'b0, ST_OK);
			end
			i = down ? n - k : k;
			r = rand_request();
			r.kind = KIND_LOAD;
			r.entry_index = 13'(i);
			r.entry_offset = layout[i];
			idle_gap();
			issue(r, 1'b0, ST_OK);
		end
	endtask

	task automatic random_lookup(int n);
		request_t r;
		int s;
		logic [63:0] lo_off, span;
		r = rand_request();
		r.kind = KIND_LOOKUP;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				if (n > 0) begin
					s = $urandom_range(n - 1);
					lo_off = layout[s];
					span = layout[s + 1] - lo_off;
					case ($urandom_range(3))
						0: r.position = lo_off;
						1: r.position = layout[s + 1] - 1;
						default: r.position = (span == 0) ? lo_off : lo_off + rand64() % span;
					endcase
				end
			end
			6: r.position = layout[n] + 64'($urandom_range(3));
			7: ;
			8: r.position = layout[n] - 1;
			default: r.position = 64'd0;
		endcase
		case ($urandom_range(9))
			0: r.request_length = 64'd0;
			1, 2, 3: r.request_length = 64'($urandom_range(1, 16));
			4, 5: r.request_length = 64'($urandom_range(1, 1 << 20));
			6: r.request_length = ALL_ONES;
			7: r.request_length = {32'b0, $urandom} + 64'd1;
			default: ;
		endcase
		idle_gap();
		issue(r, 1'b0, ST_OK);
	endtask

	initial begin : stimulus
		request_t r;
		logic [63:0] cur, gap, step;
		logic [31:0] cap;
		int n, i;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[k]) begin
			if (directed[k].op == ROW_CFG) begin
				settle();
				write_reg(directed[k].slot[7:0], directed[k].value[31:0]);
			end else begin
				r = '0;
				if (directed[k].op == ROW_LOAD) begin
					r.kind = KIND_LOAD;
					r.entry_index = directed[k].slot;
					r.entry_offset = directed[k].value;
				end else begin
					r.kind = KIND_LOOKUP;
					r.position = directed[k].value;
					r.request_length = directed[k].req_len;
				end
				issue(r, directed[k].pinned, directed[k].status);
			end
		end

		// The largest table, once; the count write saturates to MAX_SHARDS.
		idle_pct = 36;
		step = {24'b0, 8'($urandom_range(1, 255)), $urandom};
		for (i = 0; i < MAX_SHARDS; i++)
			layout[i] = step * 64'(i);
		layout[MAX_SHARDS] = ALL_ONES;
		settle();
		load_layout(MAX_SHARDS);
		settle();
		write_reg(REG_SHARD_COUNT, 32'hFFFF_FFFF);
		write_reg(REG_PAYLOAD_CAP, 32'd4096);
		repeat (WIDE_LOOKUPS) random_lookup(MAX_SHARDS);

		for (int e = 0; e < EPISODES; e++) begin
			idle_pct = (e % 3 == 0) ? 0 : (e % 3 == 1) ? 52 : 36;
			settle();
			case ($urandom_range(15))
				0: n = 0;
				1, 2: n = $urandom_range(13, 64);
				default: n = $urandom_range(1, 12);
			endcase
			case ($urandom_range(7))
				0: cap = 32'd0;
				1: cap = 32'd1;
				2: cap = $urandom_range(2, 16);
				3: cap = 32'd4096;
				4: cap = 32'hFFFF_FFFF;
				default: cap = $urandom;
			endcase
			case ($urandom_range(2))
				0: cur = 64'd0;
				1: cur = {32'b0, $urandom};
				default: cur = rand64() >> 4;
			endcase
			for (i = 0; i <= n; i++) begin
				layout[i] = cur;
				case ($urandom_range(9))
					0: gap = 64'd0;
					1, 2, 3, 4: gap = 64'($urandom_range(1, 64));
					5, 6, 7: gap = 64'($urandom_range(1, 1 << 20));
					default: gap = {24'b0, 8'($urandom), $urandom};
				endcase
				cur = cur + gap;
			end
			if ($urandom_range(3) == 0)
				layout[n] = ALL_ONES;
			// Now and then the table is not ascending.
			if ($urandom_range(6) == 0)
				repeat ($urandom_range(1, 3)) layout[$urandom_range(0, n)] = rand64();

			write_reg(REG_PAYLOAD_CAP, cap);
			if ($urandom_range(3) == 0)
				write_reg(8'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
			load_layout(n);
			settle();
			write_reg(REG_SHARD_COUNT, {19'($urandom), 13'(n)});

			for (int k = 0; k < LOOKUPS_PER_TABLE; k++) begin
				if ($urandom_range(24) == 0) begin
					i = $urandom_range(0, n);
					layout[i] = ($urandom_range(3) != 0) ? layout[i] + 64'($urandom_range(2))
						: rand64();
					r = rand_request();
					r.kind = KIND_LOAD;
					r.entry_index = 13'(i);
					r.entry_offset = layout[i];
					idle_gap();
					issue(r, 1'b0, ST_OK);
				end
				if ($urandom_range(39) == 0)
					drain_results();
				random_lookup(n);
			end
		end

		settle();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/socm_pkg.sv
rtl/socm_ram.sv
rtl/socm_div.sv
rtl/shard_offset_chunk_mapper.sv
rtl/socm_checker.sv
dv/tb.sv
